>>> rtl/core/assert_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/i2a_pkg.sv
// Shared constants, types and helpers of the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;

    localparam int VALUE_W   = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = DIGITS * 4;
    localparam int CNT_W     = $clog2(DIGITS + 1);
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int CHAR_W    = 7;

    localparam logic [1:0] FMT_UDEC   = 2'd0;
    localparam logic [1:0] FMT_SDEC   = 2'd1;
    localparam logic [1:0] FMT_HEX    = 2'd2;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [3:0]        RADIX_DEC    = 4'd10;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] digits;
        logic             neg;
    } load_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d < RADIX_DEC)
        begin
            return CHAR_ZERO + {3'b000, d};
        end
        return CHAR_UPPER_A + {3'b000, 4'(d - RADIX_DEC)};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/i2a_dabble.sv
// Bit-serial binary to BCD converter using shift and add-three.
`default_nettype none
module i2a_dabble (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [i2a_pkg::VALUE_W-1:0] mag,
    output logic                            busy,
    output logic                            done,
    output logic [i2a_pkg::BCD_W-1:0]       bcd
);
    import i2a_pkg::*;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        // Every digit of five or more is bumped by three before the shift.
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

>>> rtl/core/i2a_emit.sv
// Digit shifter that drops leading zeros and drives the character output register.
`default_nettype none
module i2a_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire i2a_pkg::load_t               load,
    output logic                              busy,
    output logic                              chr_valid,
    input  wire logic                         chr_stall,
    output logic [i2a_pkg::CHAR_W-1:0]        char_code,
    output logic                              last
);
    import i2a_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SKIP  = 4'b0010,
        E_SIGN  = 4'b0100,
        E_DIGIT = 4'b1000
    } estate_t;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGITS);

    estate_t             state_reg, state_next;
    logic [BCD_W-1:0]    digs_reg, digs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                chr_valid_reg, chr_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [3:0]          top;
    logic                slot_free;
    logic                write;

    assign top       = digs_reg[BCD_W-1 -: 4];
    assign slot_free = !chr_valid_reg || !chr_stall;

    always_comb
    begin
        state_next = state_reg;
        digs_next  = digs_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        write      = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (load.valid)
                begin
                    digs_next  = load.digits;
                    neg_next   = load.neg;
                    cnt_next   = CNT_FULL;
                    state_next = E_SKIP;
                end
            end
            E_SKIP:
            begin
                // The final digit position is always kept so that zero prints as '0'.
                if (top == 4'd0 && cnt_reg != CNT_ONE)
                begin
                    digs_next = {digs_reg[BCD_W-5:0], 4'd0};
                    cnt_next  = cnt_reg - CNT_ONE;
                end
                else
                begin
                    state_next = neg_reg ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN:
            begin
                if (slot_free)
                begin
                    write      = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                if (slot_free)
                begin
                    write     = 1'b1;
                    char_next = digit_char(top);
                    last_next = (cnt_reg == CNT_ONE);
                    digs_next = {digs_reg[BCD_W-5:0], 4'd0};
                    cnt_next  = cnt_reg - CNT_ONE;
                    if (cnt_reg == CNT_ONE)
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
        chr_valid_next = write ? 1'b1 : (chr_valid_reg && chr_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chr_valid_reg <= chr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digs_reg <= digs_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != E_IDLE);
    assign chr_valid = chr_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

>>> rtl/core/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter top level: one request at a time, text out one character a cycle
// while no pending character is stalled. Decimal: accept, shift-and-add-three conversion, load
// into the emitter, zero skip, a minus sign if negative, digits, then back to idle. Hex: loaded
// into the emitter at accept, then zero skip, digits and back to idle. A stalled pending
// character holds back the text that follows. Reset (rst_n, asynchronous) idles all control.
`default_nettype none
`include "assert_macros.svh"
module integer_to_ascii_formatter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          num_valid,
    output logic                               num_stall,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   value,
    input  wire logic [1:0]                    action,
    output logic                               chr_valid,
    input  wire logic                          chr_stall,
    output logic [i2a_pkg::CHAR_W-1:0]         char_code,
    output logic                               last
);
    import i2a_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               accept;
    logic               is_hex;
    logic               neg_in;
    logic [VALUE_W-1:0] mag;
    logic               dab_busy;
    logic               dab_done;
    logic [BCD_W-1:0]   dab_bcd;
    logic               emit_busy;
    load_t              load;

    assign num_stall = (state_reg != S_IDLE);
    assign accept    = num_valid && !num_stall;

    always_comb
    begin
        is_hex = 1'b0;
        neg_in = 1'b0;
        unique case (action)
            FMT_HEX:  is_hex = 1'b1;
            FMT_SDEC: neg_in = value[VALUE_W-1];
            FMT_UDEC: neg_in = 1'b0;
            default:  neg_in = 1'b0;   // unused selector formats as unsigned decimal
        endcase
        // Two's complement negate; the most negative value comes out right as unsigned.
        mag = neg_in ? (~value + 1'b1) : value;
    end

    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !is_hex),
        .mag   (mag),
        .busy  (dab_busy),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    always_comb
    begin
        load.valid  = (accept && is_hex) || (state_reg == S_CONV && dab_done);
        load.digits = (state_reg == S_CONV) ? dab_bcd
                                            : {{(BCD_W - VALUE_W){1'b0}}, value};
        load.neg    = (state_reg == S_CONV) ? neg_reg : 1'b0;
    end

    i2a_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .busy      (emit_busy),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .char_code (char_code),
        .last      (last)
    );

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = neg_in;
                    state_next = is_hex ? S_EMIT : S_CONV;
                end
            end
            S_CONV:
            begin
                if (dab_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    `ASSERT_NEXT(a_conv_starts, clk, rst_n, accept && !is_hex, dab_busy)
    `ASSERT_IMPLY(a_emit_idle_in_conv, clk, rst_n, state_reg == S_CONV, !emit_busy)
    `ASSERT_IMPLY(a_done_only_in_conv, clk, rst_n, dab_done, state_reg == S_CONV)
    `ASSERT_IMPLY(a_char_range, clk, rst_n, chr_valid, char_code >= 7'd45 && char_code <= 7'd70)

endmodule
`default_nettype wire

>>> bench/tb_integer_to_ascii_formatter_core.sv
// Self-checking testbench of the integer to ASCII formatter: directed and random requests.
`timescale 1ns / 100ps

typedef struct packed {
    logic [i2a_pkg::CHAR_W-1:0] code;
    logic                       last;
} text_char_t;

class text_scoreboard;
    text_char_t  expected_text[$];
    int unsigned errors;

    function new();
        errors = 0;
    endfunction

    // Works out the characters of one accepted request and queues them in order.
    function void note_number(logic [31:0] num, logic [1:0] fmt);
        logic [31:0]                mag;
        logic [31:0]                radix;
        logic [3:0]                 digit;
        logic                       neg;
        logic [i2a_pkg::CHAR_W-1:0] glyphs[$];
        text_char_t                 entry;
        mag   = num;
        radix = 32'd10;
        neg   = 1'b0;
        if (fmt == i2a_pkg::FMT_HEX)
        begin
            radix = 32'd16;
        end
        else if (fmt == i2a_pkg::FMT_SDEC && num[31])
        begin
            // Two's complement negation also gives the right magnitude for the most
            // negative value when read as unsigned.
            neg = 1'b1;
            mag = 32'd0 - num;
        end
        do
        begin
            digit = 4'(mag % radix);
            if (digit < 4'd10)
            begin
                glyphs.push_front(i2a_pkg::CHAR_ZERO + {3'b000, digit});
            end
            else
            begin
                glyphs.push_front(i2a_pkg::CHAR_UPPER_A + {3'b000, 4'(digit - 4'd10)});
            end
            mag = mag / radix;
        end
        while (mag != 32'd0);
        if (neg)
        begin
            glyphs.push_front(i2a_pkg::CHAR_MINUS);
        end
        foreach (glyphs[i])
        begin
            entry.code = glyphs[i];
            entry.last = (i == glyphs.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    function void check_char(logic [i2a_pkg::CHAR_W-1:0] code, logic last);
        text_char_t want;
        if (expected_text.size() == 0)
        begin
            $error("unexpected character: char_code %0d last %0d", code, last);
            errors++;
            return;
        end
        want = expected_text.pop_front();
        if (code !== want.code)
        begin
            $error("char_code mismatch: expected %0d actual %0d", want.code, code);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last mismatch: expected %0d actual %0d", want.last, last);
            errors++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_text.size();
    endfunction
endclass

module tb_integer_to_ascii_formatter_core;

    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_COUNT   = 246;
    localparam int QUIET_FROM     = 206;
    localparam int DIRECTED_COUNT = 24;

    logic                          clk;
    logic                          rst_n;
    logic                          num_valid;
    logic                          num_stall;
    logic [i2a_pkg::VALUE_W-1:0]   value;
    logic [1:0]                    action;
    logic                          chr_valid;
    logic                          chr_stall;
    logic [i2a_pkg::CHAR_W-1:0]    char_code;
    logic                          last;

    logic                          quiet;
    text_scoreboard                sb;

    logic [31:0] dir_value [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'd9,         32'd10,        32'h0000_000F, 32'h0000_0010,
        32'hABCD_EF01, 32'h1234_5678, 32'd999999999, 32'd1000000000,
        32'hFFFF_FFF6, 32'hC465_3600, 32'd5,         32'hFFFF_FFFF
    };
    logic [1:0] dir_action [DIRECTED_COUNT] = '{
        i2a_pkg::FMT_UDEC, i2a_pkg::FMT_SDEC, i2a_pkg::FMT_HEX,  i2a_pkg::FMT_UNUSED,
        i2a_pkg::FMT_UDEC, i2a_pkg::FMT_SDEC, i2a_pkg::FMT_HEX,  i2a_pkg::FMT_SDEC,
        i2a_pkg::FMT_UDEC, i2a_pkg::FMT_HEX,  i2a_pkg::FMT_SDEC, i2a_pkg::FMT_SDEC,
        i2a_pkg::FMT_UDEC, i2a_pkg::FMT_UDEC, i2a_pkg::FMT_HEX,  i2a_pkg::FMT_HEX,
        i2a_pkg::FMT_HEX,  i2a_pkg::FMT_HEX,  i2a_pkg::FMT_UDEC, i2a_pkg::FMT_UDEC,
        i2a_pkg::FMT_SDEC, i2a_pkg::FMT_SDEC, i2a_pkg::FMT_UNUSED, i2a_pkg::FMT_UNUSED
    };

    integer_to_ascii_formatter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .value     (value),
        .action    (action),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_number(input logic [31:0] num, input logic [1:0] fmt);
        num_valid = 1'b1;
        value     = num;
        action    = fmt;
        do
        begin
            @(posedge clk);
        end
        while (num_stall !== 1'b0);
        sb.note_number(num, fmt);
        @(negedge clk);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            num_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] num;
        case ($urandom_range(0, 5))
            0:       num = $urandom;
            1:       num = $urandom >> $urandom_range(0, 31);
            2:       num = 32'hFFFF_FFFF - ($urandom >> $urandom_range(4, 31));
            3:       num = 32'h8000_0000 ^ ($urandom >> $urandom_range(8, 31));
            4:       num = $urandom_range(0, 20);
            default: num = $urandom >> $urandom_range(16, 28);
        endcase
        return num;
    endfunction

    function automatic logic [1:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return i2a_pkg::FMT_UDEC;
        end
        else if (r < 6)
        begin
            return i2a_pkg::FMT_SDEC;
        end
        else if (r < 9)
        begin
            return i2a_pkg::FMT_HEX;
        end
        return i2a_pkg::FMT_UNUSED;
    endfunction

    // Character sink: random stall bursts, none once the run has gone quiet.
    initial
    begin
        int unsigned hold;
        hold      = 0;
        chr_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                chr_stall = 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                chr_stall = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                hold      = $urandom_range(1, 7) - 1;
                chr_stall = 1'b1;
            end
            else
            begin
                chr_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && chr_valid && !chr_stall)
        begin
            sb.check_char(char_code, last);
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((num_valid && !num_stall) || (chr_valid && !chr_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("** integer_to_ascii_formatter_core: FAILED **");
        $finish;
    end

    initial
    begin
        sb        = new();
        quiet     = 1'b0;
        rst_n     = 1'b0;
        num_valid = 1'b0;
        value     = '0;
        action    = i2a_pkg::FMT_UDEC;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            maybe_pause();
            send_number(dir_value[i], dir_action[i]);
        end

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == QUIET_FROM)
            begin
                quiet = 1'b1;
            end
            maybe_pause();
            send_number(pick_value(), pick_action());
        end
        num_valid = 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("** integer_to_ascii_formatter_core: PASSED **");
        end
        else
        begin
            $display("** integer_to_ascii_formatter_core: FAILED **");
        end
        $finish;
    end

endmodule
